// File: sv/afrc_pkg.sv
// ---------------------------------------------------------------------------
// afrc_pkg
// shared types and constants for the framed byte receiver with 8-bit sum check
// ---------------------------------------------------------------------------
`default_nettype none

package afrc_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned LenW   = 16;
  localparam int unsigned StatW  = 2;

  localparam logic [ByteW-1:0] START_BYTE = 8'h7E;
  localparam logic [ByteW-1:0] BYTE_MASK  = 8'hFF;

  typedef enum logic [StatW-1:0] {
    ST_INCOMPLETE = 2'd0,
    ST_COMPLETE   = 2'd1,
    ST_CHECKSUM   = 2'd2,
    ST_LENGTH     = 2'd3
  } afrc_status_t;

  typedef struct packed {
    afrc_status_t     status;
    logic             payload_valid;
    logic [ByteW-1:0] payload_byte;
    logic [LenW-1:0]  payload_index;
    logic [ByteW-1:0] frame_kind;
    logic [LenW-1:0]  frame_length;
  } afrc_result_t;

endpackage

`default_nettype wire

// File: sv/afrc_in_reg.sv
// ---------------------------------------------------------------------------
// afrc_in_reg
// input register: holds one received beat until the parser takes it
// ---------------------------------------------------------------------------
`default_nettype none

module afrc_in_reg
  import afrc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [ByteW-1:0] rx_byte,
  input  wire logic             take,
  output logic                  held_valid,
  output logic [ByteW-1:0]      held_byte
);

  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      held_byte <= rx_byte;
    end
  end

endmodule

`default_nettype wire

// File: sv/afrc_parser.sv
// ---------------------------------------------------------------------------
// afrc_parser
// frame state machine: start hunt, length, type, payload and checksum check
// ---------------------------------------------------------------------------
`default_nettype none

module afrc_parser
  import afrc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire logic [ByteW-1:0] rx_byte,
  output afrc_result_t          result
);

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_LEN_HI = 3'd1,
    PH_LEN_LO = 3'd2,
    PH_TYPE   = 3'd3,
    PH_BODY   = 3'd4
  } phase_t;

  phase_t           phase, phase_next;
  logic [LenW-1:0]  position, position_next;
  logic [LenW-1:0]  length_field, length_field_next;
  logic [ByteW-1:0] type_byte, type_byte_next;
  logic [ByteW-1:0] running_sum, running_sum_next;
  logic [LenW:0]    pos_plus_one;
  logic [ByteW-1:0] check;

  assign pos_plus_one = {1'b0, position} + {{LenW{1'b0}}, 1'b1};
  assign check        = running_sum + rx_byte + {{(ByteW-1){1'b0}}, 1'b1};

  always_comb begin
    phase_next        = phase;
    position_next     = position;
    length_field_next = length_field;
    type_byte_next    = type_byte;
    running_sum_next  = running_sum;
    result            = '0;
    result.status     = ST_INCOMPLETE;
    case (phase)
      PH_LEN_HI: begin
        length_field_next = {rx_byte, {ByteW{1'b0}}};
        phase_next        = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        length_field_next = {length_field[LenW-1:ByteW], rx_byte};
        if (length_field_next == '0) begin
          result.status = ST_LENGTH;
          phase_next    = PH_HUNT;
        end else begin
          phase_next    = PH_TYPE;
        end
      end
      PH_TYPE: begin
        type_byte_next   = rx_byte;
        running_sum_next = rx_byte;
        position_next    = '0;
        phase_next       = PH_BODY;
      end
      PH_BODY: begin
        if (pos_plus_one < {1'b0, length_field}) begin
          result.payload_valid = 1'b1;
          result.payload_byte  = rx_byte;
          result.payload_index = position;
          running_sum_next     = (running_sum + rx_byte) & BYTE_MASK;
          position_next        = pos_plus_one[LenW-1:0];
        end else begin
          // sum plus checksum plus one wraps to zero on a good frame
          result.status = (check == '0) ? ST_COMPLETE : ST_CHECKSUM;
          phase_next    = PH_HUNT;
        end
      end
      default: begin
        phase_next = (rx_byte == START_BYTE) ? PH_LEN_HI : PH_HUNT;
      end
    endcase
    result.frame_kind   = type_byte_next;
    result.frame_length = length_field_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      position     <= '0;
      length_field <= '0;
      type_byte    <= '0;
      running_sum  <= '0;
    end else if (step) begin
      phase        <= phase_next;
      position     <= position_next;
      length_field <= length_field_next;
      type_byte    <= type_byte_next;
      running_sum  <= running_sum_next;
    end
  end

endmodule

`default_nettype wire

// File: sv/afrc_out_reg.sv
// ---------------------------------------------------------------------------
// afrc_out_reg
// result register: holds one result beat until the receiver takes it
// ---------------------------------------------------------------------------
`default_nettype none

module afrc_out_reg
  import afrc_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load,
  input  wire afrc_result_t  result,
  output logic               space,
  output logic               out_valid,
  input  wire logic          out_ready,
  output afrc_result_t       held
);

  assign space = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (space) begin
      out_valid <= load;
    end
    if (load) begin
      held <= result;
    end
  end

endmodule

`default_nettype wire

// File: sv/api_frame_receiver_checksum_top.sv
// ---------------------------------------------------------------------------
// api_frame_receiver_checksum_top
// Framed byte receiver. Each beat on the input channel (in_valid/in_ready,
// rx_byte) yields exactly one beat on the output channel (out_valid/
// out_ready) carrying status, payload byte with its index, and the stored
// frame type and length. The block hunts for 0x7E, reads a 16-bit big-endian
// length and a type byte, streams length-1 payload bytes and checks the
// final byte so that sum + checksum + 1 is zero mod 256. A zero length
// reports a length error and the block goes back to hunting.
// Path: a byte is accepted into the input register, then its result is
// computed combinationally and loaded into the result register when that
// register has space, where it is offered. Throughput: one byte per cycle
// while the receiver keeps out_ready high; the parser state updates as a
// byte moves from the input register into the result register.
// Reset clears the frame state to hunting with zero length, type and sum,
// and empties both registers. When the receiver stalls the result register
// holds, then the input register fills, and in_ready drops only when both
// are occupied.
// ---------------------------------------------------------------------------
`default_nettype none

module api_frame_receiver_checksum_top
  import afrc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [ByteW-1:0] rx_byte,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [StatW-1:0]      status,
  output logic                  payload_valid,
  output logic [ByteW-1:0]      payload_byte,
  output logic [LenW-1:0]       payload_index,
  output logic [ByteW-1:0]      frame_kind,
  output logic [LenW-1:0]       frame_length
);

  logic             held_valid;
  logic [ByteW-1:0] held_byte;
  logic             space;
  logic             take;
  afrc_result_t     result;
  afrc_result_t     held;

  assign take = held_valid && space;

  afrc_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .take       (take),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  afrc_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (take),
    .rx_byte (held_byte),
    .result  (result)
  );

  afrc_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (take),
    .result    (result),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .held      (held)
  );

  assign status        = held.status;
  assign payload_valid = held.payload_valid;
  assign payload_byte  = held.payload_byte;
  assign payload_index = held.payload_index;
  assign frame_kind    = held.frame_kind;
  assign frame_length  = held.frame_length;

endmodule

`default_nettype wire
